// ===== rtl/core/tpwq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwq_pkg
// Types, constants and helper functions for the tag pose window qualifier.
// ----------------------------------------------------------------------------
package tpwq_pkg;

    localparam int WINDOW_SIZE_DEF = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_COUNT  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORI_COS_SQ   = 3'd4;

    localparam logic [9:0]  RST_EXPECTED_ID = 10'd0;
    localparam logic [18:0] RST_MAX_AGE     = 19'd250000;
    localparam logic [23:0] RST_MAX_WINDOW  = 24'd1000000;
    localparam logic [19:0] RST_MAX_POS     = 20'd15000;
    localparam logic [31:0] RST_ORI_COS_SQ  = 32'd4292283556;

    // stream widths
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 8;

    // per-entry check code
    typedef enum logic [1:0] {
        ENT_OK    = 2'd0,
        ENT_FAMID = 2'd1,
        ENT_HAM   = 2'd2,
        ENT_AGE   = 2'd3
    } entry_code_t;

    typedef enum logic [3:0] {
        V_OK    = 4'd0,
        V_UNREG = 4'd1,
        V_FEW   = 4'd2,
        V_FAMID = 4'd3,
        V_HAM   = 4'd4,
        V_AGE   = 4'd5,
        V_SPAN  = 4'd6,
        V_POS   = 4'd7,
        V_ORI   = 4'd8
    } verdict_t;

    // shared multiplier operations
    typedef enum logic [4:0] {
        MOP_NONE, MOP_LIM,
        MOP_PX, MOP_PY, MOP_PZ,
        MOP_DOT0, MOP_DOT1, MOP_DOT2, MOP_DOT3,
        MOP_NA0, MOP_NA1, MOP_NA2, MOP_NA3,
        MOP_NB0, MOP_NB1, MOP_NB2, MOP_NB3,
        MOP_DD, MOP_NN, MOP_CHI, MOP_CLO
    } mul_op_t;

    typedef enum logic [2:0] {
        CS_IDLE, CS_START, CS_SCAN, CS_SPAN,
        CS_LOAD_A, CS_LOAD_B, CS_PAIR, CS_FINISH
    } ctl_state_t;

    localparam int STEP_W     = 5;
    localparam logic [STEP_W-1:0] CHECK_STEP = 5'd21;

    typedef struct packed {
        logic    store;
        logic    scan_first;
        logic    scan_step;
        logic    load_a;
        logic    load_b;
        mul_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic        registered;
        logic        full;
        entry_code_t rd_code;
        logic        span_fail;
        logic        pos_fail;
        logic        ori_fail;
    } dp_status_t;

    function automatic logic id_registered(input logic [9:0] id);
        return (id == 10'd10) || (id == 10'd11) || (id == 10'd12) || (id == 10'd20)
            || (id == 10'd101) || (id == 10'd102) || (id == 10'd103);
    endfunction

    // Pair sequence: operands issue one a cycle; each product is registered, then added into its accumulator.
    function automatic mul_op_t step_op(input logic [STEP_W-1:0] step);
        mul_op_t op;
        case (step)
            5'd0:    op = MOP_PX;
            5'd1:    op = MOP_PY;
            5'd2:    op = MOP_PZ;
            5'd3:    op = MOP_DOT0;
            5'd4:    op = MOP_DOT1;
            5'd5:    op = MOP_DOT2;
            5'd6:    op = MOP_DOT3;
            5'd7:    op = MOP_NA0;
            5'd8:    op = MOP_NA1;
            5'd9:    op = MOP_NA2;
            5'd10:   op = MOP_NA3;
            5'd11:   op = MOP_NB0;
            5'd12:   op = MOP_NB1;
            5'd13:   op = MOP_NB2;
            5'd14:   op = MOP_NB3;
            5'd15:   op = MOP_DD;
            5'd16:   op = MOP_NN;
            5'd18:   op = MOP_CHI;
            5'd19:   op = MOP_CLO;
            default: op = MOP_NONE;
        endcase
        return op;
    endfunction

    function automatic verdict_t code_verdict(input entry_code_t c);
        verdict_t v;
        unique case (c)
            ENT_OK:    v = V_OK;
            ENT_FAMID: v = V_FAMID;
            ENT_HAM:   v = V_HAM;
            ENT_AGE:   v = V_AGE;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tpwq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwq_datapath
// Window storage, configuration registers and the shared multiplier.
// ----------------------------------------------------------------------------
module tpwq_datapath #(
    parameter int WINDOW_SIZE = tpwq_pkg::WINDOW_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpwq_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(WINDOW_SIZE)-1:0]   rd_idx,
    output tpwq_pkg::dp_status_t             status,
    input  logic                             cfg_we,
    input  logic [tpwq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpwq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [9:0]                       tag_id,
    input  logic                             family_match,
    input  logic [3:0]                       hamming_bits,
    input  logic signed [19:0]               receive_age_us,
    input  logic [39:0]                      receive_time_us,
    input  logic signed [23:0]               pos_x,
    input  logic signed [23:0]               pos_y,
    input  logic signed [23:0]               pos_z,
    input  logic signed [15:0]               quat_x,
    input  logic signed [15:0]               quat_y,
    input  logic signed [15:0]               quat_z,
    input  logic signed [15:0]               quat_w
);
    import tpwq_pkg::*;

    localparam int SW = $clog2(WINDOW_SIZE);
    localparam int FW = $clog2(WINDOW_SIZE + 1);

    logic [9:0]  expected_id_reg;
    logic [18:0] max_age_reg;
    logic [23:0] max_window_reg;
    logic [19:0] max_pos_reg;
    logic [31:0] cos_sq_reg;

    logic [SW-1:0] ws_reg;
    logic [FW-1:0] fill_reg;

    entry_code_t code_reg [WINDOW_SIZE];
    logic [39:0] time_reg [WINDOW_SIZE];
    logic [23:0] pos_reg  [WINDOW_SIZE][3];
    logic [15:0] quat_reg [WINDOW_SIZE][4];

    logic [23:0] sa_pos_reg [3];
    logic [23:0] sb_pos_reg [3];
    logic [15:0] sa_q_reg   [4];
    logic [15:0] sb_q_reg   [4];

    logic [39:0] tmin_reg, tmax_reg;

    logic signed [67:0] prod_reg;
    mul_op_t            op_d_reg;
    logic [39:0]        lim_reg;
    logic [49:0]        pos_acc_reg;
    logic signed [33:0] dot_acc_reg;
    logic [32:0]        na_reg, nb_reg;
    logic [65:0]        nn_reg;
    logic [64:0]        dd_reg, rhs_hi_reg, rhs_lo_reg;

    entry_code_t        code_in;
    logic               cfg_clear;
    logic [SW:0]        rd_sum;
    logic [SW-1:0]      rd_slot;
    logic signed [24:0] diff;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [33:0]        dot_abs;
    logic [96:0]        lhs;
    logic [97:0]        rhs;
    logic [1:0]         k_sel;

    assign cfg_clear = cfg_we && (cfg_index < CFG_IDX_W'(CFG_COUNT));

    always_comb
    begin
        if (!family_match || (tag_id != expected_id_reg))
            code_in = ENT_FAMID;
        else if (hamming_bits != 4'd0)
            code_in = ENT_HAM;
        else if (receive_age_us[19] || (receive_age_us[18:0] > max_age_reg))
            code_in = ENT_AGE;
        else
            code_in = ENT_OK;
    end

    // logical window position to physical slot, oldest first
    assign rd_sum  = {1'b0, ws_reg} + {1'b0, rd_idx};
    assign rd_slot = (rd_sum >= (SW+1)'(WINDOW_SIZE)) ?
                     SW'(rd_sum - (SW+1)'(WINDOW_SIZE)) : rd_sum[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= RST_EXPECTED_ID;
            max_age_reg     <= RST_MAX_AGE;
            max_window_reg  <= RST_MAX_WINDOW;
            max_pos_reg     <= RST_MAX_POS;
            cos_sq_reg      <= RST_ORI_COS_SQ;
            ws_reg          <= '0;
            fill_reg        <= '0;
            op_d_reg        <= MOP_NONE;
        end
        else
        begin
            op_d_reg <= cmd.op;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EXPECTED_ID: expected_id_reg <= cfg_wdata[9:0];
                    CFG_MAX_AGE:     max_age_reg     <= cfg_wdata[18:0];
                    CFG_MAX_WINDOW:  max_window_reg  <= cfg_wdata[23:0];
                    CFG_MAX_POS:     max_pos_reg     <= cfg_wdata[19:0];
                    CFG_ORI_COS_SQ:  cos_sq_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cfg_clear)
            begin
                ws_reg   <= '0;
                fill_reg <= '0;
            end
            else if (cmd.store)
            begin
                ws_reg <= (ws_reg == SW'(WINDOW_SIZE - 1)) ? '0 : ws_reg + SW'(1);
                if (fill_reg != FW'(WINDOW_SIZE))
                    fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    // window storage and operand shadows
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            code_reg[ws_reg]    <= code_in;
            time_reg[ws_reg]    <= receive_time_us;
            pos_reg[ws_reg][0]  <= pos_x;
            pos_reg[ws_reg][1]  <= pos_y;
            pos_reg[ws_reg][2]  <= pos_z;
            quat_reg[ws_reg][0] <= quat_x;
            quat_reg[ws_reg][1] <= quat_y;
            quat_reg[ws_reg][2] <= quat_z;
            quat_reg[ws_reg][3] <= quat_w;
        end
        if (cmd.scan_first)
        begin
            tmin_reg <= time_reg[rd_slot];
            tmax_reg <= time_reg[rd_slot];
        end
        else if (cmd.scan_step)
        begin
            if (time_reg[rd_slot] < tmin_reg)
                tmin_reg <= time_reg[rd_slot];
            if (time_reg[rd_slot] > tmax_reg)
                tmax_reg <= time_reg[rd_slot];
        end
        if (cmd.load_a)
        begin
            sa_pos_reg <= pos_reg[rd_slot];
            sa_q_reg   <= quat_reg[rd_slot];
        end
        if (cmd.load_b)
        begin
            sb_pos_reg <= pos_reg[rd_slot];
            sb_q_reg   <= quat_reg[rd_slot];
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.op)
            MOP_PY:  k_sel = 2'd1;
            MOP_PZ:  k_sel = 2'd2;
            default: k_sel = 2'd0;
        endcase
        diff    = $signed({sa_pos_reg[k_sel][23], sa_pos_reg[k_sel]})
                - $signed({sb_pos_reg[k_sel][23], sb_pos_reg[k_sel]});
        dot_abs = dot_acc_reg[33] ? 34'(-dot_acc_reg) : 34'(dot_acc_reg);
        mul_a   = '0;
        mul_b   = '0;
        unique case (cmd.op)
            MOP_NONE: ;
            MOP_LIM:
            begin
                mul_a = $signed({14'd0, max_pos_reg});
                mul_b = $signed({14'd0, max_pos_reg});
            end
            MOP_PX, MOP_PY, MOP_PZ:
            begin
                mul_a = {{9{diff[24]}}, diff};
                mul_b = {{9{diff[24]}}, diff};
            end
            MOP_DOT0:
            begin
                mul_a = {{18{sa_q_reg[0][15]}}, sa_q_reg[0]};
                mul_b = {{18{sb_q_reg[0][15]}}, sb_q_reg[0]};
            end
            MOP_DOT1:
            begin
                mul_a = {{18{sa_q_reg[1][15]}}, sa_q_reg[1]};
                mul_b = {{18{sb_q_reg[1][15]}}, sb_q_reg[1]};
            end
            MOP_DOT2:
            begin
                mul_a = {{18{sa_q_reg[2][15]}}, sa_q_reg[2]};
                mul_b = {{18{sb_q_reg[2][15]}}, sb_q_reg[2]};
            end
            MOP_DOT3:
            begin
                mul_a = {{18{sa_q_reg[3][15]}}, sa_q_reg[3]};
                mul_b = {{18{sb_q_reg[3][15]}}, sb_q_reg[3]};
            end
            MOP_NA0:
            begin
                mul_a = {{18{sa_q_reg[0][15]}}, sa_q_reg[0]};
                mul_b = {{18{sa_q_reg[0][15]}}, sa_q_reg[0]};
            end
            MOP_NA1:
            begin
                mul_a = {{18{sa_q_reg[1][15]}}, sa_q_reg[1]};
                mul_b = {{18{sa_q_reg[1][15]}}, sa_q_reg[1]};
            end
            MOP_NA2:
            begin
                mul_a = {{18{sa_q_reg[2][15]}}, sa_q_reg[2]};
                mul_b = {{18{sa_q_reg[2][15]}}, sa_q_reg[2]};
            end
            MOP_NA3:
            begin
                mul_a = {{18{sa_q_reg[3][15]}}, sa_q_reg[3]};
                mul_b = {{18{sa_q_reg[3][15]}}, sa_q_reg[3]};
            end
            MOP_NB0:
            begin
                mul_a = {{18{sb_q_reg[0][15]}}, sb_q_reg[0]};
                mul_b = {{18{sb_q_reg[0][15]}}, sb_q_reg[0]};
            end
            MOP_NB1:
            begin
                mul_a = {{18{sb_q_reg[1][15]}}, sb_q_reg[1]};
                mul_b = {{18{sb_q_reg[1][15]}}, sb_q_reg[1]};
            end
            MOP_NB2:
            begin
                mul_a = {{18{sb_q_reg[2][15]}}, sb_q_reg[2]};
                mul_b = {{18{sb_q_reg[2][15]}}, sb_q_reg[2]};
            end
            MOP_NB3:
            begin
                mul_a = {{18{sb_q_reg[3][15]}}, sb_q_reg[3]};
                mul_b = {{18{sb_q_reg[3][15]}}, sb_q_reg[3]};
            end
            MOP_DD:
            begin
                mul_a = $signed(dot_abs);
                mul_b = $signed(dot_abs);
            end
            MOP_NN:
            begin
                mul_a = $signed({1'b0, na_reg});
                mul_b = $signed({1'b0, nb_reg});
            end
            MOP_CHI:
            begin
                mul_a = $signed({1'b0, nn_reg[65:33]});
                mul_b = $signed({2'b0, cos_sq_reg});
            end
            MOP_CLO:
            begin
                mul_a = $signed({1'b0, nn_reg[32:0]});
                mul_b = $signed({2'b0, cos_sq_reg});
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // product register, then accumulate from the registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        unique case (op_d_reg)
            MOP_NONE: ;
            MOP_LIM:  lim_reg     <= prod_reg[39:0];
            MOP_PX:   pos_acc_reg <= prod_reg[49:0];
            MOP_PY, MOP_PZ:
                      pos_acc_reg <= pos_acc_reg + prod_reg[49:0];
            MOP_DOT0: dot_acc_reg <= prod_reg[33:0];
            MOP_DOT1, MOP_DOT2, MOP_DOT3:
                      dot_acc_reg <= dot_acc_reg + prod_reg[33:0];
            MOP_NA0:  na_reg      <= prod_reg[32:0];
            MOP_NA1, MOP_NA2, MOP_NA3:
                      na_reg      <= na_reg + prod_reg[32:0];
            MOP_NB0:  nb_reg      <= prod_reg[32:0];
            MOP_NB1, MOP_NB2, MOP_NB3:
                      nb_reg      <= nb_reg + prod_reg[32:0];
            MOP_DD:   dd_reg      <= prod_reg[64:0];
            MOP_NN:   nn_reg      <= prod_reg[65:0];
            MOP_CHI:  rhs_hi_reg  <= prod_reg[64:0];
            MOP_CLO:  rhs_lo_reg  <= prod_reg[64:0];
        endcase
    end

    assign lhs = {dd_reg, 32'd0};
    assign rhs = {rhs_hi_reg, 33'd0} + {33'd0, rhs_lo_reg};

    always_comb
    begin
        status.registered = id_registered(expected_id_reg);
        status.full       = (fill_reg == FW'(WINDOW_SIZE));
        status.rd_code    = code_reg[rd_slot];
        status.span_fail  = (tmax_reg - tmin_reg) > {16'd0, max_window_reg};
        status.pos_fail   = {14'd0, pos_acc_reg} > {24'd0, lim_reg};
        status.ori_fail   = (na_reg == '0) || (nb_reg == '0) || ({1'b0, lhs} < rhs);
    end

endmodule

// ===== rtl/core/tpwq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwq_ctrl
// Sequencer for the window checks and the result register.
// ----------------------------------------------------------------------------
module tpwq_ctrl #(
    parameter int WINDOW_SIZE = tpwq_pkg::WINDOW_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpwq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output tpwq_pkg::dp_cmd_t                  cmd,
    output logic [$clog2(WINDOW_SIZE)-1:0]     rd_idx,
    input  tpwq_pkg::dp_status_t               status
);
    import tpwq_pkg::*;

    localparam int SW = $clog2(WINDOW_SIZE);

    ctl_state_t          state_reg, state_next;
    logic [SW-1:0]       i_reg, i_next, j_reg, j_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    verdict_t            verdict_reg, verdict_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_load;

    assign out_load = (state_reg == CS_FINISH) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        step_next    = step_reg;
        verdict_next = verdict_reg;
        unique case (state_reg)
            CS_IDLE:
                if (s_tvalid)
                    state_next = CS_START;
            CS_START:
            begin
                i_next = '0;
                if (!status.registered)
                begin
                    verdict_next = V_UNREG;
                    state_next   = CS_FINISH;
                end
                else if (!status.full)
                begin
                    verdict_next = V_FEW;
                    state_next   = CS_FINISH;
                end
                else
                    state_next = CS_SCAN;
            end
            CS_SCAN:
            begin
                if (status.rd_code != ENT_OK)
                begin
                    verdict_next = code_verdict(status.rd_code);
                    state_next   = CS_FINISH;
                end
                else if (i_reg == SW'(WINDOW_SIZE - 1))
                    state_next = CS_SPAN;
                else
                    i_next = i_reg + SW'(1);
            end
            CS_SPAN:
            begin
                i_next = '0;
                j_next = SW'(1);
                if (status.span_fail)
                begin
                    verdict_next = V_SPAN;
                    state_next   = CS_FINISH;
                end
                else
                    state_next = CS_LOAD_A;
            end
            CS_LOAD_A:
                state_next = CS_LOAD_B;
            CS_LOAD_B:
            begin
                step_next  = '0;
                state_next = CS_PAIR;
            end
            CS_PAIR:
            begin
                if (step_reg == CHECK_STEP)
                begin
                    if (status.pos_fail)
                    begin
                        verdict_next = V_POS;
                        state_next   = CS_FINISH;
                    end
                    else if (status.ori_fail)
                    begin
                        verdict_next = V_ORI;
                        state_next   = CS_FINISH;
                    end
                    else if (j_reg == SW'(WINDOW_SIZE - 1))
                    begin
                        if (i_reg == SW'(WINDOW_SIZE - 2))
                        begin
                            verdict_next = V_OK;
                            state_next   = CS_FINISH;
                        end
                        else
                        begin
                            i_next     = i_reg + SW'(1);
                            j_next     = i_reg + SW'(2);
                            state_next = CS_LOAD_A;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + SW'(1);
                        state_next = CS_LOAD_A;
                    end
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            CS_FINISH:
                if (out_load)
                    state_next = CS_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.op         = MOP_NONE;
        s_tready       = 1'b0;
        rd_idx         = i_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.store = s_tvalid;
            end
            CS_START: ;
            CS_SCAN:
            begin
                cmd.scan_first = (i_reg == '0);
                cmd.scan_step  = (i_reg != '0);
            end
            CS_SPAN:
                cmd.op = MOP_LIM;
            CS_LOAD_A:
                cmd.load_a = 1'b1;
            CS_LOAD_B:
            begin
                rd_idx     = j_reg;
                cmd.load_b = 1'b1;
            end
            CS_PAIR:
                cmd.op = step_op(step_reg);
            CS_FINISH:
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'd0, verdict_reg == V_OK, verdict_reg};
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            verdict_reg   <= V_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            step_reg      <= step_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_accepted_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[4] == (out_data_reg[3:0] == V_OK)))
        else $error("accepted flag disagrees with verdict");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[3:0] <= V_ORI))
        else $error("verdict code out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_PAIR) |-> (j_reg > i_reg))
        else $error("pair indices out of order");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == CS_START))
        else $error("accepted transaction did not start evaluation");

endmodule

// ===== rtl/core/tag_pose_window_qualifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_pose_window_qualifier_top
// Qualifies a sliding window of fiducial-tag pose observations.
// ----------------------------------------------------------------------------
// Each input transaction is one tag observation. It is stored in a window of
// the last WINDOW_SIZE observations (oldest dropped) and one verdict
// transaction follows for the whole window. Checks, first failure wins:
// expected ID in the registry, window full, per-entry family/ID, hamming and
// age (oldest first), time span, then every pair (oldest first) for position
// spread and quaternion angle spread. Any configuration write to a listed
// register empties the window. Sequence: accept, start, a scan of up to
// WINDOW_SIZE entries, the span check, then per pair two operand loads plus
// a 22-step sequence on the single shared 34x34 multiplier, and finally the
// result register. A new transaction is taken while the previous verdict
// still waits on the master side.
// ----------------------------------------------------------------------------
module tag_pose_window_qualifier_top #(
    parameter int WINDOW_SIZE = tpwq_pkg::WINDOW_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tag_id[9:0], family_match[10], hamming_bits[14:11], receive_age_us[34:15],
    // receive_time_us[74:35], pos_x[98:75], pos_y[122:99], pos_z[146:123],
    // quat_x[162:147], quat_y[178:163], quat_z[194:179], quat_w[210:195]
    input  logic [tpwq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // verdict[3:0], accepted[4]
    output logic [tpwq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [tpwq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpwq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tpwq_pkg::*;

    dp_cmd_t                        cmd;
    dp_status_t                     status;
    logic [$clog2(WINDOW_SIZE)-1:0] rd_idx;

    // sequencer: walks the checks and holds the verdict for the master side
    tpwq_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .status   (status)
    );

    // datapath: window storage, registers, shared multiplier
    tpwq_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_idx          (rd_idx),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .tag_id          (s_tdata[9:0]),
        .family_match    (s_tdata[10]),
        .hamming_bits    (s_tdata[14:11]),
        .receive_age_us  ($signed(s_tdata[34:15])),
        .receive_time_us (s_tdata[74:35]),
        .pos_x           ($signed(s_tdata[98:75])),
        .pos_y           ($signed(s_tdata[122:99])),
        .pos_z           ($signed(s_tdata[146:123])),
        .quat_x          ($signed(s_tdata[162:147])),
        .quat_y          ($signed(s_tdata[178:163])),
        .quat_z          ($signed(s_tdata[194:179])),
        .quat_w          ($signed(s_tdata[210:195]))
    );

endmodule
